[src/gbrf_pkg.sv]
// Package for the grid route finder: word types, status and direction codes.
// No dependencies.
package gbrf_pkg;

  localparam int unsigned GRID_W = 8;

  localparam logic [2:0] ST_STEP   = 3'd0;
  localparam logic [2:0] ST_RANGE  = 3'd1;
  localparam logic [2:0] ST_WALL   = 3'd2;
  localparam logic [2:0] ST_SAME   = 3'd3;
  localparam logic [2:0] ST_UNREACH = 3'd4;
  localparam logic [2:0] ST_LOAD   = 3'd5;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [2:0] cell_row;
    logic [2:0] cell_col;
    logic       cell_wall;
    logic [2:0] origin_row;
    logic [2:0] origin_col;
    logic [3:0] dest_row;
    logic [3:0] dest_col;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] direction;
    logic       last;
  } out_word_t;

  // one queue entry: cell, parent index, direction taken
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    logic [5:0] parent;
    logic [1:0] dir;
  } q_entry_t;

endpackage

[src/grid_bfs_route_finder_core.sv]
// Grid route finder top level: sequencer, wall/visited memories, queue and route stack.
// Depends on gbrf_pkg and gbrf_nbr.
//
// Usage: drive in_word and raise start while busy is low; the word is taken at that
// edge. After reset a pass clears the wall and visited memories, with busy high. A
// load word writes one wall bit; its load done word goes out from S_STATUS. A find
// word passes through S_CHECK for the range, wall and same-cell checks (a failing
// check sends its status word from S_STATUS), then a pass clears the visited memory,
// then each queued cell is fetched from the queue memory in S_QREAD and S_QWAIT, and
// each neighbor (up, right, down, left) goes through the shared step unit in S_NBR,
// which forms the cell and reads wall/visited, and S_NCHK, which decides. When the
// destination is hit the route is traced back through the queue, one S_TRREAD and
// S_TRWAIT pass per step, onto the route stack, then played out one word per S_SREAD
// and S_SWAIT pass, origin first, with last on the final step. Each result is on
// out_word for one cycle with out_valid; the receiver cannot stall. busy falls in the
// cycle the final word is out, so the next word can be accepted at the edge that ends
// it.
// Reset clears the control state; queue and stack contents are not cleared.
module grid_bfs_route_finder_core
  import gbrf_pkg::*;
#(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CHECK, S_CLEAR, S_QREAD, S_QWAIT, S_NBR, S_NCHK, S_TRREAD,
    S_TRWAIT, S_SREAD, S_SWAIT, S_STATUS
  } state_t;

  state_t    state_r;
  in_word_t  req_r;
  logic [6:0]  head_r, tail_r;
  logic [1:0]  d_r;
  logic [2:0]  cur_row_r, cur_col_r;
  logic [6:0]  len_r;
  logic [5:0]  idx_r;
  logic [5:0]  clr_r;
  logic [2:0]  st_r;
  logic        ov_r;
  out_word_t   ow_r;

  q_entry_t queue_mem [64];
  logic [1:0] stack_mem [64];
  logic       wall_mem [64];
  logic       vis_mem [64];
  q_entry_t q_rd_r;
  logic [1:0] s_rd_r;
  logic       w_rd_r;
  logic       v_rd_r;

  logic [2:0] nrow, ncol;
  logic       nin;
  logic [5:0] ncell;

  gbrf_nbr #(.ROWS(ROWS), .COLS(COLS)) u_nbr (
    .row(cur_row_r), .col(cur_col_r), .dir(d_r),
    .nrow(nrow), .ncol(ncol), .inside_grid(nin)
  );

  assign ncell = {nrow, ncol};

  logic dest_oor, org_oor, dest_wall, hit, enq;
  assign dest_oor  = (req_r.dest_row >= 4'(ROWS)) || (req_r.dest_col >= 4'(COLS));
  assign org_oor   = ({1'b0, req_r.origin_row} >= 4'(ROWS)) ||
                     ({1'b0, req_r.origin_col} >= 4'(COLS));
  // wall bit of the destination, read at acceptance, valid in S_CHECK
  assign dest_wall = w_rd_r;
  assign hit = nin && ({1'b0, nrow} == req_r.dest_row) && ({1'b0, ncol} == req_r.dest_col);
  assign enq = (state_r == S_NCHK) && nin && !w_rd_r && !v_rd_r && !tail_r[6];

  // memories
  logic       q_we;
  logic [5:0] q_wa, q_ra;
  q_entry_t   q_wd;
  logic       s_we;
  logic [5:0] s_wa, s_ra;
  logic [1:0] s_wd;
  logic       w_we, w_wd;
  logic [5:0] w_wa, w_ra;
  logic       v_we, v_wd;
  logic [5:0] v_wa, v_ra;

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[q_wa] <= q_wd;
    q_rd_r <= queue_mem[q_ra];
    if (s_we) stack_mem[s_wa] <= s_wd;
    s_rd_r <= stack_mem[s_ra];
    if (w_we) wall_mem[w_wa] <= w_wd;
    w_rd_r <= wall_mem[w_ra];
    if (v_we) vis_mem[v_wa] <= v_wd;
    v_rd_r <= vis_mem[v_ra];
  end

  always_comb begin
    q_we = 1'b0; q_wa = tail_r[5:0]; q_wd = '0;
    q_ra = (state_r == S_QREAD) ? head_r[5:0] : idx_r;
    s_we = 1'b0; s_wa = len_r[5:0]; s_wd = d_r;
    s_ra = len_r[5:0] - 6'd1;
    w_we = 1'b0; w_wa = clr_r; w_wd = 1'b0;
    w_ra = (state_r == S_IDLE) ? {in_word.dest_row[2:0], in_word.dest_col[2:0]} : ncell;
    v_we = 1'b0; v_wa = clr_r; v_wd = 1'b0;
    v_ra = ncell;
    if (state_r == S_INIT) begin
      w_we = 1'b1;
      v_we = 1'b1;
    end else if (state_r == S_IDLE && start && !in_word.cmd &&
                 {1'b0, in_word.cell_row} < 4'(ROWS) &&
                 {1'b0, in_word.cell_col} < 4'(COLS)) begin
      w_we = 1'b1;
      w_wa = {in_word.cell_row, in_word.cell_col};
      w_wd = in_word.cell_wall;
    end else if (state_r == S_CLEAR) begin
      // clearing pass marks the origin as it goes by
      v_we = 1'b1;
      v_wd = (clr_r == {req_r.origin_row, req_r.origin_col});
    end
    if (state_r == S_CHECK && !dest_oor && !dest_wall && !org_oor &&
        !({1'b0, req_r.origin_row} == req_r.dest_row &&
          {1'b0, req_r.origin_col} == req_r.dest_col)) begin
      q_we = 1'b1; q_wa = 6'd0;
      q_wd = '{row: req_r.origin_row, col: req_r.origin_col, parent: 6'd0, dir: 2'd0};
    end else if (enq) begin
      q_we = 1'b1;
      q_wd = '{row: nrow, col: ncol, parent: head_r[5:0], dir: d_r};
      v_we = 1'b1; v_wa = ncell; v_wd = 1'b1;
    end else if (state_r == S_NBR && hit) begin
      s_we = 1'b1; s_wa = 6'd0; s_wd = d_r;
    end else if (state_r == S_TRWAIT) begin
      s_we = 1'b1; s_wa = len_r[5:0]; s_wd = q_rd_r.dir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      head_r <= '0;
      tail_r <= '0;
      ov_r <= 1'b0;
      len_r <= '0;
      clr_r <= '0;
    end else begin
      ov_r <= 1'b0;
      unique case (state_r)
        S_INIT: begin
          clr_r <= clr_r + 6'd1;
          if (clr_r == 6'd63) state_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          req_r <= in_word;
          if (!in_word.cmd) begin
            st_r <= ST_LOAD;
            state_r <= S_STATUS;
          end else begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (dest_oor) begin
            st_r <= ST_RANGE; state_r <= S_STATUS;
          end else if (dest_wall) begin
            st_r <= ST_WALL; state_r <= S_STATUS;
          end else if ({1'b0, req_r.origin_row} == req_r.dest_row &&
                       {1'b0, req_r.origin_col} == req_r.dest_col) begin
            st_r <= ST_SAME; state_r <= S_STATUS;
          end else if (org_oor) begin
            st_r <= ST_UNREACH; state_r <= S_STATUS;
          end else begin
            clr_r <= '0;
            head_r <= 7'd0;
            tail_r <= 7'd1;
            state_r <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          clr_r <= clr_r + 6'd1;
          if (clr_r == 6'd63) state_r <= S_QREAD;
        end
        S_QREAD: begin
          if (head_r < tail_r && !head_r[6]) state_r <= S_QWAIT;
          else begin
            st_r <= ST_UNREACH; state_r <= S_STATUS;
          end
        end
        S_QWAIT: begin
          cur_row_r <= q_rd_r.row;
          cur_col_r <= q_rd_r.col;
          d_r <= DIR_UP;
          state_r <= S_NBR;
        end
        S_NBR: begin
          if (hit) begin
            len_r <= 7'd1;
            idx_r <= head_r[5:0];
            state_r <= (head_r[5:0] == 6'd0) ? S_SREAD : S_TRREAD;
          end else begin
            state_r <= S_NCHK;
          end
        end
        S_NCHK: begin
          if (enq) tail_r <= tail_r + 7'd1;
          d_r <= d_r + 2'd1;
          if (d_r == DIR_LEFT) begin
            head_r <= head_r + 7'd1;
            state_r <= S_QREAD;
          end else begin
            state_r <= S_NBR;
          end
        end
        S_TRREAD: state_r <= S_TRWAIT;
        S_TRWAIT: begin
          len_r <= len_r + 7'd1;
          idx_r <= q_rd_r.parent;
          if (q_rd_r.parent == 6'd0 || len_r == 7'd63) state_r <= S_SREAD;
          else state_r <= S_TRREAD;
        end
        S_SREAD: state_r <= S_SWAIT;
        S_SWAIT: begin
          ov_r <= 1'b1;
          ow_r <= '{status: ST_STEP, direction: s_rd_r, last: (len_r == 7'd1)};
          len_r <= len_r - 7'd1;
          state_r <= (len_r == 7'd1) ? S_IDLE : S_SREAD;
        end
        S_STATUS: begin
          ov_r <= 1'b1;
          ow_r <= '{status: st_r, direction: 2'd0, last: 1'b1};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_word = ow_r;

  property p_tail_bound;
    @(posedge clk) disable iff (!rst_n) tail_r <= 7'd64;
  endproperty
  a_tail_bound: assert property (p_tail_bound) else $error("queue tail past end");

  property p_head_tail;
    @(posedge clk) disable iff (!rst_n) (state_r == S_NBR) |-> (head_r < tail_r);
  endproperty
  a_head_tail: assert property (p_head_tail) else $error("expanding empty queue");

  property p_status_last;
    @(posedge clk) disable iff (!rst_n)
      (out_valid && out_word.status != ST_STEP) |-> (out_word.last && out_word.direction == 2'd0);
  endproperty
  a_status_last: assert property (p_status_last) else $error("status word malformed");

  property p_last_idle;
    @(posedge clk) disable iff (!rst_n) (out_valid && out_word.last) |-> !busy;
  endproperty
  a_last_idle: assert property (p_last_idle) else $error("busy after last word");

endmodule

[src/gbrf_nbr.sv]
// Neighbor step unit: one cell plus one direction, with grid bound check.
// Depends on gbrf_pkg.
module gbrf_nbr
  import gbrf_pkg::*;
#(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  logic [2:0] row,
  input  logic [2:0] col,
  input  logic [1:0] dir,
  output logic [2:0] nrow,
  output logic [2:0] ncol,
  output logic       inside_grid
);
  logic [3:0] r4, c4;
  always_comb begin
    r4 = {1'b0, row};
    c4 = {1'b0, col};
    inside_grid = 1'b1;
    unique case (dir)
      DIR_UP: begin
        if (row == 3'd0) inside_grid = 1'b0;
        r4 = {1'b0, row} - 4'd1;
      end
      DIR_RIGHT: c4 = {1'b0, col} + 4'd1;
      DIR_DOWN:  r4 = {1'b0, row} + 4'd1;
      default: begin
        if (col == 3'd0) inside_grid = 1'b0;
        c4 = {1'b0, col} - 4'd1;
      end
    endcase
    if (r4 >= 4'(ROWS) || c4 >= 4'(COLS)) inside_grid = 1'b0;
    nrow = r4[2:0];
    ncol = c4[2:0];
  end
endmodule
